// ===== design/ilm_pkg.sv =====
// ----------------------------------------------------------------------------
// ilm_pkg
// shared constants, opcodes and controller/datapath interface types for the
// interrupt load meter
// ----------------------------------------------------------------------------
package ilm_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

  localparam int TS_W      = 32;
  localparam int PM_W      = 10;
  localparam int CNT_W     = 32;
  localparam int AVG_W     = 18;
  localparam int Q_SHIFT   = 8;
  localparam int AVG_SHIFT = 4;

  localparam int PROD_W     = TS_W + PM_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);
  localparam int OUT_DATA_W = 4 * PM_W + 4 * CNT_W;

  localparam logic [PM_W-1:0]  FULL_SCALE = PM_W'(1000);
  localparam logic [TS_W-1:0]  LIMIT_80   = TS_W'(800);
  localparam logic [TS_W-1:0]  LIMIT_90   = TS_W'(900);
  localparam logic [TS_W-1:0]  LIMIT_100  = TS_W'(1000);
  localparam logic [AVG_W:0]   Q_ROUND    = (AVG_W + 1)'(1 << (Q_SHIFT - 1));
  localparam logic [AVG_W-1:0] AVG_MAX    = AVG_W'(1000 << Q_SHIFT);

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_END      = 2'd1,
    OP_PEAK_CLR = 2'd2,
    OP_MEAS_CLR = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic begin_ev;
    logic peak_clr;
    logic meas_clr;
    logic mul;
    logic div_step;
    logic update;
    logic scan_init;
    logic scan_step;
    logic scan_end;
    logic out_load;
  } ilm_cmd_t;

  typedef struct packed {
    op_e  op;
    logic enabled;
    logic period_nz;
    logic div_last;
    logic scan_done;
  } ilm_sts_t;

endpackage

// ===== design/ilm_ram.sv =====
// ----------------------------------------------------------------------------
// ilm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ilm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ilm_dp.sv =====
// ----------------------------------------------------------------------------
// ilm_dp
// load meter datapath: period tracking, product and restoring divider,
// average, peaks, counters, window ring scan and result snapshot
// ----------------------------------------------------------------------------
module ilm_dp
  import ilm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic                  cfg_wr_data_i,
  input  logic [1:0]            in_op_i,
  input  logic [TS_W-1:0]       in_ts_i,
  input  ilm_cmd_t              cmd_i,
  output ilm_sts_t              sts_o,
  output logic                  out_taken_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  // input word
  op_e             op_q;
  logic [TS_W-1:0] ts_q;

  // control and statistics state
  logic                 en_q;
  logic                 armed_q;
  logic [TS_W-1:0]      busy_q;
  logic [TS_W-1:0]      prev_q;
  logic [TS_W-1:0]      period_q;
  logic [PM_W-1:0]      latest_q;
  logic [AVG_W-1:0]     avg_q;
  logic [PM_W-1:0]      peak_q;
  logic [PM_W-1:0]      recent_q;
  logic [WIN_AW-1:0]    pos_q;
  logic [FILL_W-1:0]    fill_q;
  logic [CNT_W-1:0]     c80_q;
  logic [CNT_W-1:0]     c90_q;
  logic [CNT_W-1:0]     c100_q;
  logic [CNT_W-1:0]     seen_q;
  logic                 taken_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [FILL_W-1:0]    k_q;
  logic                 rdv_q;
  logic [PM_W-1:0]      best_q;

  // divider payload
  logic [PROD_W-1:0] quo_q;
  logic [TS_W-1:0]   rem_q;

  // result snapshot
  logic                  out_taken_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [TS_W-1:0]   elapsed;
  logic [PROD_W-1:0] product;
  logic [TS_W:0]     rem_sh;
  logic              rem_ge;
  logic [TS_W-1:0]   rem_d;
  logic [TS_W-1:0]   raw;
  logic [PM_W-1:0]   pm;
  logic [AVG_W-1:0]  target;
  logic [AVG_W:0]    diff;
  logic [AVG_W:0]    step;
  logic [AVG_W-1:0]  avg_d;
  logic [WIN_AW-1:0] pos_d;
  logic [PM_W-1:0]   ram_rdata;
  logic [PM_W-1:0]   best_d;
  logic [AVG_W:0]    avg_rnd;

  assign elapsed = ts_q - busy_q;
  assign product = PROD_W'(elapsed) * PROD_W'(FULL_SCALE);

  // one restoring step per cycle
  assign rem_sh = {rem_q, quo_q[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, period_q};
  assign rem_d  = rem_ge ? TS_W'(rem_sh - {1'b0, period_q}) : rem_sh[TS_W-1:0];

  assign raw    = quo_q[TS_W-1:0];
  assign pm     = (raw > LIMIT_100) ? FULL_SCALE : raw[PM_W-1:0];
  assign target = {pm, {Q_SHIFT{1'b0}}};
  assign diff   = $signed({1'b0, target}) - $signed({1'b0, avg_q});
  assign step   = $signed(diff) >>> AVG_SHIFT;
  assign avg_d  = (seen_q == '0) ? target : avg_q + step[AVG_W-1:0];
  assign pos_d  = (pos_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;

  assign best_d = (rdv_q && (ram_rdata > best_q)) ? ram_rdata : best_q;

  assign avg_rnd = {1'b0, avg_q} + Q_ROUND;

  ilm_ram #(
    .WIDTH (PM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (pos_q),
    .wdata_i (pm),
    .raddr_i (k_q[WIN_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_BEGIN;
      en_q     <= 1'b1;
      armed_q  <= 1'b0;
      busy_q   <= '0;
      prev_q   <= '0;
      period_q <= '0;
      latest_q <= '0;
      avg_q    <= '0;
      peak_q   <= '0;
      recent_q <= '0;
      pos_q    <= '0;
      fill_q   <= '0;
      c80_q    <= '0;
      c90_q    <= '0;
      c100_q   <= '0;
      seen_q   <= '0;
      taken_q  <= 1'b0;
      dcnt_q   <= '0;
      k_q      <= '0;
      rdv_q    <= 1'b0;
      best_q   <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        en_q <= cfg_wr_data_i;
      end
      if (cmd_i.load) begin
        op_q    <= op_e'(in_op_i);
        taken_q <= 1'b0;
      end
      if (cmd_i.begin_ev) begin
        armed_q  <= 1'b1;
        period_q <= armed_q ? ts_q - prev_q : '0;
        prev_q   <= ts_q;
        busy_q   <= ts_q;
      end
      if (cmd_i.peak_clr) begin
        peak_q <= '0;
      end
      if (cmd_i.meas_clr) begin
        latest_q <= '0;
        avg_q    <= '0;
        peak_q   <= '0;
        recent_q <= '0;
        pos_q    <= '0;
        fill_q   <= '0;
        c80_q    <= '0;
        c90_q    <= '0;
        c100_q   <= '0;
        seen_q   <= '0;
      end
      if (cmd_i.mul) begin
        taken_q <= 1'b1;
        dcnt_q  <= '0;
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.update) begin
        latest_q <= pm;
        avg_q    <= avg_d;
        if (pm > peak_q) begin
          peak_q <= pm;
        end
        pos_q <= pos_d;
        if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        if (raw > LIMIT_80) begin
          c80_q <= c80_q + 1'b1;
        end
        if (raw > LIMIT_90) begin
          c90_q <= c90_q + 1'b1;
        end
        if (raw > LIMIT_100) begin
          c100_q <= c100_q + 1'b1;
        end
        seen_q <= seen_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        k_q    <= '0;
        rdv_q  <= 1'b0;
        best_q <= '0;
      end
      if (cmd_i.scan_step) begin
        k_q    <= k_q + 1'b1;
        rdv_q  <= k_q < fill_q;
        best_q <= best_d;
      end
      if (cmd_i.scan_end) begin
        recent_q <= best_d;
        rdv_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ts_q <= in_ts_i;
    end
    if (cmd_i.mul) begin
      quo_q <= product;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[PROD_W-2:0], rem_ge};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      out_taken_q <= taken_q;
      out_data_q  <= {seen_q, c100_q, c90_q, c80_q, recent_q, peak_q,
                      avg_rnd[Q_SHIFT +: PM_W], latest_q};
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.enabled   = en_q;
  assign sts_o.period_nz = period_q != '0;
  assign sts_o.div_last  = dcnt_q == DIV_CNT_W'(PROD_W - 1);
  assign sts_o.scan_done = k_q == FILL_W'(WINDOW_DEPTH);

  assign out_taken_o = out_taken_q;
  assign out_data_o  = out_data_q;

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_q <= AVG_MAX)
    else $error("average left its range");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < period_q))
    else $error("divider remainder not below divisor");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (fill_q <= FILL_W'(WINDOW_DEPTH)) && (fill_q != '0))
    else $error("window fill out of range after a sample");

endmodule

// ===== design/ilm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilm_ctrl
// load meter sequencer: accepts and decodes an event, runs product, divide,
// update and window scan on a sampling end, then loads the output register
// ----------------------------------------------------------------------------
module ilm_ctrl
  import ilm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ilm_sts_t sts_i,
  output ilm_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_OUT;
        case (sts_i.op)
          OP_BEGIN: begin
            cmd_o.begin_ev = sts_i.enabled;
          end
          OP_END: begin
            if (sts_i.enabled && sts_i.period_nz) begin
              cmd_o.mul = 1'b1;
              state_d   = ST_DIV;
            end
          end
          OP_PEAK_CLR: begin
            cmd_o.peak_clr = 1'b1;
          end
          OP_MEAS_CLR: begin
            cmd_o.meas_clr = 1'b1;
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update    = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.scan_end = 1'b1;
          state_d        = ST_OUT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_DECODE)
    else $error("accepted word not decoded");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_last) |=> state_q == ST_DIV)
    else $error("divider left early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output word dropped while stalled");

endmodule

// ===== design/interrupt_load_meter.sv =====
// ----------------------------------------------------------------------------
// interrupt_load_meter
// one event at a time; an end word that takes a sample runs the 42-step
//   restoring divider and the one-entry-per-cycle window ring scan
// reset: asynchronous active low; statistics clear, counting enabled
// ----------------------------------------------------------------------------
module interrupt_load_meter
  import ilm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic                  cfg_wr_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TS_W-1:0]       s_axis_tdata,  // timestamp
  input  logic [1:0]            s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // latest load, mean load, peak load, window peak, count above 800,
  // count above 900, count above 1000, sample total
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser   // sample_taken
);

  ilm_cmd_t cmd;
  ilm_sts_t sts;

  ilm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ilm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_op_i       (s_axis_tuser),
    .in_ts_i       (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_taken_o   (m_axis_tuser),
    .out_data_o    (m_axis_tdata)
  );

endmodule

// ===== tb/tb_interrupt_load_meter.sv =====
// ----------------------------------------------------------------------------
// tb_interrupt_load_meter
// Self-checking bench for the interrupt load meter. Begin, end and clear
// events go in on the input stream. A local predictor tracks the period,
// the busy fraction, the moving average, the peaks, the window and the
// threshold counters, and it holds one expected report per event. Every
// report on the output stream is checked field by field against the oldest
// one. The run covers directed corner events, a phase with counting off,
// random begin/end sequences with noise, a long output stall and a final
// stretch with no gaps.
// ----------------------------------------------------------------------------
module tb_interrupt_load_meter;
  import ilm_pkg::*;

  typedef struct {
    logic        taken;
    logic [9:0]  last_pm;
    logic [9:0]  avg_pm;
    logic [9:0]  peak_pm;
    logic [9:0]  recent_pm;
    logic [31:0] over80;
    logic [31:0] over90;
    logic [31:0] over100;
    logic [31:0] samples;
  } meter_report_t;

  localparam int HOLD_CYCLES = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_wr_en_i;
  logic                  cfg_wr_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TS_W-1:0]       s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // predictor state
  logic        m_counting = 1'b1;
  logic [31:0] m_busy_from = '0;
  logic [31:0] m_prev_begin = '0;
  logic [31:0] m_period = '0;
  logic        m_armed = 1'b0;
  logic [9:0]  m_latest = '0;
  logic [17:0] m_avg_q8 = '0;
  logic [9:0]  m_peak = '0;
  logic [9:0]  m_recent = '0;
  logic [9:0]  m_ring [WINDOW_DEPTH];
  int          m_ring_pos = 0;
  int          m_ring_fill = 0;
  logic [31:0] m_over80 = '0;
  logic [31:0] m_over90 = '0;
  logic [31:0] m_over100 = '0;
  logic [31:0] m_samples = '0;

  meter_report_t pending_reports[$];
  logic [31:0]   event_clock = '0;
  bit            gaps_enabled = 1'b1;
  bit            sink_hold = 1'b0;
  int            events_sent = 0;
  int            samples_predicted = 0;
  int            reports_checked = 0;
  int            mismatches = 0;

  interrupt_load_meter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic meter_report_t meter_predict(op_e op, logic [31:0] ts);
    meter_report_t    r;
    logic [31:0]      elapsed;
    logic [63:0]      prod;
    logic [31:0]      raw;
    logic [9:0]       pm;
    int signed        diff;
    int signed        avg_next;
    logic [18:0]      avg_round;
    r.taken = 1'b0;
    case (op)
      OP_BEGIN: begin
        if (m_counting) begin
          m_period     = m_armed ? ts - m_prev_begin : '0;
          m_armed      = 1'b1;
          m_prev_begin = ts;
          m_busy_from  = ts;
        end
      end
      OP_END: begin
        if (m_counting && m_period != '0) begin
          elapsed  = ts - m_busy_from;
          prod     = {32'd0, elapsed} * 64'd1000;
          raw      = 32'(prod / {32'd0, m_period});
          pm       = (raw > LIMIT_100) ? FULL_SCALE : raw[9:0];
          m_latest = pm;
          if (m_samples == '0) begin
            m_avg_q8 = {pm, 8'd0};
          end else begin
            diff     = $signed({14'd0, pm, 8'd0}) - $signed({14'd0, m_avg_q8});
            avg_next = $signed({14'd0, m_avg_q8}) + (diff >>> AVG_SHIFT);
            m_avg_q8 = avg_next[17:0];
          end
          if (pm > m_peak) m_peak = pm;
          m_ring[m_ring_pos] = pm;
          m_ring_pos = (m_ring_pos + 1) % WINDOW_DEPTH;
          if (m_ring_fill < WINDOW_DEPTH) m_ring_fill++;
          m_recent = '0;
          for (int k = 0; k < m_ring_fill; k++) begin
            if (m_ring[k] > m_recent) m_recent = m_ring[k];
          end
          if (raw > LIMIT_80) m_over80++;
          if (raw > LIMIT_90) m_over90++;
          if (raw > LIMIT_100) m_over100++;
          m_samples++;
          samples_predicted++;
          r.taken = 1'b1;
        end
      end
      OP_PEAK_CLR: m_peak = '0;
      default: begin
        m_latest    = '0;
        m_avg_q8    = '0;
        m_peak      = '0;
        m_recent    = '0;
        m_ring_pos  = 0;
        m_ring_fill = 0;
        m_over80    = '0;
        m_over90    = '0;
        m_over100   = '0;
        m_samples   = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) m_ring[k] = '0;
      end
    endcase
    avg_round   = {1'b0, m_avg_q8} + 19'd128;
    r.last_pm   = m_latest;
    r.avg_pm    = avg_round[17:8];
    r.peak_pm   = m_peak;
    r.recent_pm = m_recent;
    r.over80    = m_over80;
    r.over90    = m_over90;
    r.over100   = m_over100;
    r.samples   = m_samples;
    return r;
  endfunction

  task automatic send_event(op_e op, logic [31:0] ts);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ts;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(meter_predict(op, ts));
    events_sent++;
  endtask

  // begin after a random period, then one or two ends after a random busy time
  task automatic send_cycle();
    logic [31:0] span;
    logic [31:0] busy;
    case ($urandom_range(0, 3))
      0:       span = $urandom_range(1, 64);
      1:       span = $urandom_range(65, 200000);
      2:       span = $urandom_range(200001, 32'h7fff_ffff);
      default: span = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       busy = '0;
      1:       busy = span;
      2:       busy = span - 32'($urandom_range(0, span / 5));
      3:       busy = span + 32'($urandom_range(0, span));
      default: busy = $urandom_range(0, span);
    endcase
    event_clock = event_clock + span;
    send_event(OP_BEGIN, event_clock);
    send_event(OP_END, event_clock + busy);
    if ($urandom_range(0, 7) == 0)
      send_event(OP_END, event_clock + busy + 32'($urandom_range(0, 40)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_counting(logic en);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= en;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    m_counting = en;
  endtask

  task automatic test_directed_events();
    send_event(OP_END, 32'h0000_0000);
    send_event(OP_BEGIN, 32'hffff_ffff);
    send_event(OP_END, 32'h0000_0005);
    send_event(OP_BEGIN, 32'hffff_ffff);
    send_event(OP_END, 32'h0000_0000);
    send_event(OP_BEGIN, 32'd999);
    send_event(OP_END, 32'd999);
    send_event(OP_END, 32'd1999);
    send_event(OP_END, 32'd1849);
    send_event(OP_END, 32'd1949);
    send_event(OP_END, 32'hffff_ffff);
    send_event(OP_PEAK_CLR, 32'h0000_0000);
    send_event(OP_END, 32'd1499);
    send_event(OP_BEGIN, 32'hffff_fffe);
    send_event(OP_END, 32'h7fff_fffd);
    send_event(OP_MEAS_CLR, 32'hffff_ffff);
    send_event(OP_END, 32'h0000_1000);
    send_event(OP_BEGIN, 32'h8000_0000);
    send_event(OP_END, 32'hc000_0000);
    send_event(OP_BEGIN, 32'h8000_0001);
    send_event(OP_END, 32'h8000_0001);
    send_event(OP_END, 32'h8000_0002);
    send_event(OP_END, 32'h8000_0003);
    send_event(OP_PEAK_CLR, 32'h5555_5555);
    send_event(OP_MEAS_CLR, 32'haaaa_aaaa);
    event_clock = 32'h8000_0001;
  endtask

  task automatic test_counting_disabled();
    set_counting(1'b0);
    repeat (6) send_cycle();
    send_event(OP_PEAK_CLR, $urandom);
    repeat (4) send_event(op_e'($urandom_range(0, 3)), $urandom);
    send_event(OP_MEAS_CLR, $urandom);
    repeat (3) send_cycle();
    set_counting(1'b1);
    send_event(OP_END, m_busy_from + 32'd7);
    repeat (4) send_cycle();
  endtask

  task automatic test_random_traffic(int n);
    int goal;
    int pick;
    goal = events_sent + n;
    while (events_sent < goal) begin
      pick = $urandom_range(0, 29);
      if (pick < 23) send_cycle();
      else if (pick < 26) send_event(op_e'($urandom_range(0, 3)), $urandom);
      else if (pick == 26) send_event(OP_PEAK_CLR, $urandom);
      else if (pick == 27) send_event(OP_MEAS_CLR, $urandom);
      else if (pick == 28) send_event(OP_BEGIN, event_clock);
      else send_event(OP_END, $urandom);
    end
  endtask

  task automatic test_toggled_counting();
    test_random_traffic(300);
    set_counting(1'b0);
    test_random_traffic(40);
    set_counting(1'b1);
    test_random_traffic(300);
  endtask

  task automatic test_output_hold();
    sink_hold = 1'b1;
    repeat (15) send_cycle();
    while (sink_hold) @(posedge clk_i);
  endtask

  initial begin : sink_ready
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d %s: expected %0d, actual %0d", reports_checked, name,
                 want, got);
    end
  endtask

  always @(posedge clk_i) begin
    meter_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report word, sample_count %0d", m_axis_tdata[167:136]);
      end else begin
        want = pending_reports.pop_front();
        compare_field("sample_taken", want.taken, m_axis_tuser);
        compare_field("latest_load", want.last_pm, m_axis_tdata[9:0]);
        compare_field("mean_load", want.avg_pm, m_axis_tdata[19:10]);
        compare_field("top_load", want.peak_pm, m_axis_tdata[29:20]);
        compare_field("window_top", want.recent_pm, m_axis_tdata[39:30]);
        compare_field("above_800", want.over80, m_axis_tdata[71:40]);
        compare_field("above_900", want.over90, m_axis_tdata[103:72]);
        compare_field("above_1000", want.over100, m_axis_tdata[135:104]);
        compare_field("sample_count", want.samples, m_axis_tdata[167:136]);
      end
      reports_checked++;
    end
  end

  initial begin
    for (int k = 0; k < WINDOW_DEPTH; k++) m_ring[k] = '0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_counting(1'b1);
    test_directed_events();
    test_counting_disabled();
    test_toggled_counting();
    test_output_hold();
    gaps_enabled = 1'b0;
    test_random_traffic(120);
    drain();
    repeat (80) @(posedge clk_i);
    $display("%0d events sent, %0d load samples, %0d reports checked, %0d mismatches",
             events_sent, samples_predicted, reports_checked, mismatches);
    $display("covered corner events, counting off and on, random traffic and a long stall");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
